// ----- rtl/core/two_tier_fabric_next_hop_macros.svh -----
// assertion macros shared by the next-hop selector rtl
`ifndef TWO_TIER_FABRIC_NEXT_HOP_MACROS_SVH
`define TWO_TIER_FABRIC_NEXT_HOP_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define TTFNH_ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be true outside reset
`define TTFNH_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define TTFNH_ASSERT_PROP(lbl, clk, rst, prop, msg)
`define TTFNH_ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

// ----- rtl/core/ttfnh_pkg.sv -----
// shared types and codes of the fabric next-hop selector
package ttfnh_pkg;

   // link kinds of a request
   localparam logic [1:0] LINK_TO_HOST   = 2'd0;
   localparam logic [1:0] LINK_FROM_HOST = 2'd1;
   localparam logic [1:0] LINK_TO_CORE   = 2'd2;
   localparam logic [1:0] LINK_FROM_CORE = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_ARRIVED = 2'd0;
   localparam logic [1:0] KIND_HOSTQ   = 2'd1;
   localparam logic [1:0] KIND_PORT    = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   // control register indexes
   localparam logic [1:0] CSR_HOSTS_PER_RACK = 2'd0;
   localparam logic [1:0] CSR_CORE_COUNT     = 2'd1;
   localparam logic [1:0] CSR_BALANCE_MODE   = 2'd2;

   localparam int HOST_W  = 10;
   localparam int COUNT_W = 7;
   localparam int SPRAY_W = 6;
   localparam int DVD_W   = 32;
   localparam int STEP_W  = 6;

   typedef struct packed {
      logic                 start;
      logic [DVD_W-1:0]     dividend;   // left aligned, steps bits used
      logic [COUNT_W-1:0]   divisor;    // 1..64
      logic [STEP_W-1:0]    steps;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DVD_W-1:0]     quotient;   // low steps bits hold the quotient
      logic [SPRAY_W-1:0]   remainder;
   } div_rsp_type;

endpackage

// ----- rtl/core/ttfnh_ram.sv -----
// generic single write port ram with registered read
module ttfnh_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 1024
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/ttfnh_div.sv -----
// bit-serial restoring divider for small divisors
module ttfnh_div (
   input  logic                    clock,
   input  logic                    reset,
   input  ttfnh_pkg::div_req_type  req,
   output ttfnh_pkg::div_rsp_type  rsp
);

   logic                              active_ff;
   logic                              done_ff;
   logic [ttfnh_pkg::DVD_W-1:0]       shreg_ff;
   logic [ttfnh_pkg::SPRAY_W-1:0]     rem_ff;
   logic [ttfnh_pkg::COUNT_W-1:0]     divisor_ff;
   logic [ttfnh_pkg::STEP_W-1:0]      cnt_ff;
   logic [ttfnh_pkg::COUNT_W-1:0]     trial;
   logic                              fits;

   // partial remainder stays below the divisor, so one more bit fits in 7 bits
   assign trial = {rem_ff, shreg_ff[ttfnh_pkg::DVD_W-1]};
   assign fits  = (trial >= divisor_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            active_ff <= 1'b1;
         end else if (active_ff && (cnt_ff == ttfnh_pkg::STEP_W'(1))) begin
            active_ff <= 1'b0;
            done_ff   <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         shreg_ff   <= req.dividend;
         rem_ff     <= '0;
         divisor_ff <= req.divisor;
         cnt_ff     <= req.steps;
      end else if (active_ff) begin
         shreg_ff <= {shreg_ff[ttfnh_pkg::DVD_W-2:0], fits};
         rem_ff   <= fits ? ttfnh_pkg::SPRAY_W'(trial - divisor_ff)
                          : trial[ttfnh_pkg::SPRAY_W-1:0];
         cnt_ff   <= cnt_ff - ttfnh_pkg::STEP_W'(1);
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = shreg_ff;
   assign rsp.remainder = rem_ff;

endmodule

// ----- rtl/core/two_tier_fabric_next_hop.sv -----
// next-hop selector for a two-tier leaf/spine fabric, top level
//
// One request names a packet on a link; one result names the queue it enters
// next. A request is taken when start is high and busy is low; busy stays high
// while the request is worked on and drops in the cycle the result is shown.
// The result is on the rsp_ ports for exactly one cycle, marked by rsp_valid,
// and cannot be held off by the receiver.
// All division goes through one bit-serial divider, one quotient bit a cycle,
// so latency follows from how many divides a request needs: error, arrival
// and host-link requests need none; rack lookups and core-to-agg ports need
// one; same-rack turnaround needs two; spray and hash uplinks need three, the
// last of them a 6-bit modulo for spray and a 32-bit modulo for hash. After
// reset the spray table is cleared one entry a cycle, with busy high; the csr_
// port takes writes at any time and is always ready, but registers should
// only be changed while busy is low.
`include "two_tier_fabric_next_hop_macros.svh"

module two_tier_fabric_next_hop #(
   parameter int MAX_HOSTS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_link_kind,
   input  logic [9:0]  req_link_host,
   input  logic [9:0]  req_pkt_src,
   input  logic [9:0]  req_pkt_dst,
   input  logic [31:0] req_flow_id,
   // result channel
   output logic        rsp_valid,
   output logic [1:0]  rsp_next_kind,
   output logic [6:0]  rsp_next_port,
   output logic [9:0]  rsp_next_host,
   // control registers
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_data
);

   // only ids up to 1023 can ever reach the table
   localparam int SPRAY_DEPTH = (MAX_HOSTS < 1024) ? MAX_HOSTS : 1024;
   localparam int AW          = $clog2(SPRAY_DEPTH);
   localparam int HW          = ttfnh_pkg::HOST_W;
   localparam int CW          = ttfnh_pkg::COUNT_W;
   localparam int SW          = ttfnh_pkg::SPRAY_W;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_DST,
      ST_SRC,
      ST_MOD
   } state_type;

   state_type            state_ff, state_in;
   logic [AW-1:0]        clr_ff;

   // control registers
   logic [CW-1:0]        hpr_ff;
   logic [CW-1:0]        cores_ff;
   logic                 mode_ff;

   // latched request
   logic [1:0]           kind_ff;
   logic [HW-1:0]        lhost_ff;
   logic [HW-1:0]        src_ff;
   logic [HW-1:0]        dst_ff;
   logic [31:0]          flow_ff;

   // destination rack and host port
   logic [HW-1:0]        dq_ff;
   logic [SW-1:0]        dr_ff;

   // result registers
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_kind_ff, rsp_kind_in;
   logic [CW-1:0]        rsp_port_ff, rsp_port_in;
   logic [HW-1:0]        rsp_host_ff, rsp_host_in;

   logic [CW-1:0]        hpr_use;
   logic [CW-1:0]        cores_use;
   logic                 id_err;
   logic [31:0]          hash_sum;
   logic [CW-1:0]        up_inc;

   ttfnh_pkg::div_req_type div_req;
   ttfnh_pkg::div_rsp_type div_rsp;

   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [SW-1:0]        mem_wdata;
   logic [SW-1:0]        mem_rdata;

   // counts out of range are used clamped to 1..64
   always_comb begin
      if (hpr_ff == '0) begin
         hpr_use = CW'(1);
      end else if (hpr_ff > CW'(64)) begin
         hpr_use = CW'(64);
      end else begin
         hpr_use = hpr_ff;
      end
      if (cores_ff == '0) begin
         cores_use = CW'(1);
      end else if (cores_ff > CW'(64)) begin
         cores_use = CW'(64);
      end else begin
         cores_use = cores_ff;
      end
   end

   // host ids beyond the fabric; link host only matters on host links
   assign id_err = ({22'd0, src_ff} >= 32'(MAX_HOSTS))
                || ({22'd0, dst_ff} >= 32'(MAX_HOSTS))
                || (((kind_ff == ttfnh_pkg::LINK_TO_HOST)
                     || (kind_ff == ttfnh_pkg::LINK_FROM_HOST))
                    && ({22'd0, lhost_ff} >= 32'(MAX_HOSTS)));

   assign hash_sum = flow_ff + {22'd0, src_ff} + {22'd0, dst_ff};

   // next spray position, wraps at the core count
   assign up_inc = {1'b0, div_rsp.remainder} + CW'(1);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = ttfnh_pkg::KIND_ERROR;
      rsp_port_in  = '0;
      rsp_host_in  = '0;
      div_req      = '0;
      mem_we       = 1'b0;
      mem_waddr    = lhost_ff[AW-1:0];
      mem_wdata    = (up_inc == cores_use) ? '0 : up_inc[SW-1:0];
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            if (clr_ff == AW'(SPRAY_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // everything that needs no divide answers here
            if (id_err) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (kind_ff == ttfnh_pkg::LINK_TO_HOST) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (dst_ff == lhost_ff) begin
                  rsp_kind_in = ttfnh_pkg::KIND_HOSTQ;
                  rsp_host_in = dst_ff;
               end
            end else if ((kind_ff == ttfnh_pkg::LINK_FROM_HOST) && (dst_ff == lhost_ff)) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = ttfnh_pkg::KIND_ARRIVED;
               state_in     = ST_IDLE;
            end else if ((kind_ff == ttfnh_pkg::LINK_FROM_HOST) && (src_ff != lhost_ff)) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               // destination rack and port within the rack
               div_req.start    = 1'b1;
               div_req.dividend = {dst_ff, 22'd0};
               div_req.divisor  = hpr_use;
               div_req.steps    = ttfnh_pkg::STEP_W'(HW);
               state_in         = ST_DST;
            end
         end
         ST_DST: begin
            if (div_rsp.done) begin
               if (kind_ff == ttfnh_pkg::LINK_TO_CORE) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
                  // rack index wider than a port is an error
                  if (div_rsp.quotient[HW-1:CW] == '0) begin
                     rsp_kind_in = ttfnh_pkg::KIND_PORT;
                     rsp_port_in = div_rsp.quotient[CW-1:0];
                  end
               end else if (kind_ff == ttfnh_pkg::LINK_FROM_CORE) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = ttfnh_pkg::KIND_PORT;
                  rsp_port_in  = {1'b0, div_rsp.remainder};
                  state_in     = ST_IDLE;
               end else begin
                  // source rack, to tell same-rack from cross-rack
                  div_req.start    = 1'b1;
                  div_req.dividend = {src_ff, 22'd0};
                  div_req.divisor  = hpr_use;
                  div_req.steps    = ttfnh_pkg::STEP_W'(HW);
                  state_in         = ST_SRC;
               end
            end
         end
         ST_SRC: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient[HW-1:0] == dq_ff) begin
                  // same rack, turn around at the aggregation switch
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = ttfnh_pkg::KIND_PORT;
                  rsp_port_in  = {1'b0, dr_ff};
                  state_in     = ST_IDLE;
               end else begin
                  div_req.start   = 1'b1;
                  div_req.divisor = cores_use;
                  if (mode_ff) begin
                     div_req.dividend = hash_sum;
                     div_req.steps    = ttfnh_pkg::STEP_W'(32);
                  end else begin
                     // stale entries above a lowered core count are reduced too
                     div_req.dividend = {mem_rdata, 26'd0};
                     div_req.steps    = ttfnh_pkg::STEP_W'(SW);
                  end
                  state_in = ST_MOD;
               end
            end
         end
         ST_MOD: begin
            if (div_rsp.done) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = ttfnh_pkg::KIND_PORT;
               rsp_port_in  = hpr_use + {1'b0, div_rsp.remainder};
               mem_we       = !mode_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + AW'(1);
         end
      end
      rsp_kind_ff <= rsp_kind_in;
      rsp_port_ff <= rsp_port_in;
      rsp_host_ff <= rsp_host_in;
   end

   // request capture and divider results
   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && start) begin
         kind_ff  <= req_link_kind;
         lhost_ff <= req_link_host;
         src_ff   <= req_pkt_src;
         dst_ff   <= req_pkt_dst;
         flow_ff  <= req_flow_id;
      end
      if ((state_ff == ST_DST) && div_rsp.done) begin
         dq_ff <= div_rsp.quotient[HW-1:0];
         dr_ff <= div_rsp.remainder;
      end
   end

   // control registers; writes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         hpr_ff   <= CW'(16);
         cores_ff <= CW'(4);
         mode_ff  <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            ttfnh_pkg::CSR_HOSTS_PER_RACK: hpr_ff   <= csr_data;
            ttfnh_pkg::CSR_CORE_COUNT:     cores_ff <= csr_data;
            ttfnh_pkg::CSR_BALANCE_MODE:   mode_ff  <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   ttfnh_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // per-source-host spray position
   ttfnh_ram #(
      .WIDTH (SW),
      .DEPTH (SPRAY_DEPTH)
   ) u_spray (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (lhost_ff[AW-1:0]),
      .rd_data (mem_rdata)
   );

   assign busy          = (state_ff != ST_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_next_kind = rsp_kind_ff;
   assign rsp_next_port = rsp_port_ff;
   assign rsp_next_host = rsp_host_ff;

   `TTFNH_ASSERT_PROP(a_rsp_after_work, clock, reset,
      rsp_valid |-> $past(busy), "result without a request in progress")
   `TTFNH_ASSERT_PROP(a_rsp_single, clock, reset,
      rsp_valid |=> !rsp_valid, "result strobe longer than one cycle")
   `TTFNH_ASSERT_PROP(a_host_only_hostq, clock, reset,
      (rsp_valid && (rsp_next_kind != ttfnh_pkg::KIND_HOSTQ)) |-> (rsp_next_host == '0),
      "host field set on a non host-queue result")
   `TTFNH_ASSERT_NEVER(a_spray_in_range, clock, reset,
      mem_we && (state_ff != ST_CLEAR) && ({1'b0, mem_wdata} >= cores_use),
      "spray position written at or above core count")

endmodule

// ----- sim/two_tier_fabric_next_hop_tb.sv -----
// testbench for the fabric next-hop selector, directed and random requests
module two_tier_fabric_next_hop_tb;

   localparam int CYCLE_LIMIT = 400000;

   // one request: a packet sitting on a link
   typedef struct packed {
      logic [1:0]  kind;
      logic [9:0]  lhost;
      logic [9:0]  src;
      logic [9:0]  dst;
      logic [31:0] flow;
   } req_type;

   // one next-hop decision
   typedef struct packed {
      logic [1:0] kind;
      logic [6:0] port;
      logic [9:0] host;
   } hop_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_link_kind = '0;
   logic [9:0]  req_link_host = '0;
   logic [9:0]  req_pkt_src = '0;
   logic [9:0]  req_pkt_dst = '0;
   logic [31:0] req_flow_id = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_next_kind;
   logic [6:0]  rsp_next_port;
   logic [9:0]  rsp_next_host;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [6:0]  csr_data = '0;

   // register copies as written, raw 7-bit values
   logic [6:0]  cfg_hosts_per_rack = 7'd16;
   logic [6:0]  cfg_core_count = 7'd4;
   logic        cfg_balance_mode = 1'b0;

   // next uplink per source host for spraying
   logic [5:0]  spray_next [1024];

   hop_type     expected_hops [$];
   int          mismatches = 0;
   int          cycles = 0;
   int          idle_pct = 0;

   two_tier_fabric_next_hop u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_link_kind (req_link_kind),
      .req_link_host (req_link_host),
      .req_pkt_src   (req_pkt_src),
      .req_pkt_dst   (req_pkt_dst),
      .req_flow_id   (req_flow_id),
      .rsp_valid     (rsp_valid),
      .rsp_next_kind (rsp_next_kind),
      .rsp_next_port (rsp_next_port),
      .rsp_next_host (rsp_next_host),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #4 clock = ~clock;

   // run-away guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // counts are used clamped to 1..64
   function automatic int unsigned clamp_count(input logic [6:0] v);
      if (v == 7'd0) return 1;
      if (v > 7'd64) return 64;
      return v;
   endfunction

   // next hop of one request, advances the spray entry on sprayed uplinks
   function automatic hop_type route_packet(input req_type r);
      hop_type     h;
      int unsigned hpr;
      int unsigned cores;
      int unsigned up;
      int unsigned rack;
      logic [31:0] hash_sum;
      h = '{kind: ttfnh_pkg::KIND_ERROR, port: 7'd0, host: 10'd0};
      hpr = clamp_count(cfg_hosts_per_rack);
      cores = clamp_count(cfg_core_count);
      // ids are 10 bits wide, so none can reach past the fabric size
      case (r.kind)
         ttfnh_pkg::LINK_TO_HOST: begin
            if (r.dst == r.lhost) begin
               h.kind = ttfnh_pkg::KIND_HOSTQ;
               h.host = r.dst;
            end
         end
         ttfnh_pkg::LINK_FROM_HOST: begin
            if (r.dst == r.lhost) begin
               h.kind = ttfnh_pkg::KIND_ARRIVED;
            end else if (r.src == r.lhost) begin
               h.kind = ttfnh_pkg::KIND_PORT;
               if (r.src / hpr == r.dst / hpr) begin
                  // same rack, turn around at the agg switch
                  h.port = 7'(r.dst % hpr);
               end else begin
                  if (cfg_balance_mode == 1'b0) begin
                     // stale entries above a lowered count wrap here
                     up = spray_next[r.lhost] % cores;
                     spray_next[r.lhost] = 6'((up + 1) % cores);
                  end else begin
                     hash_sum = r.src + r.dst + r.flow;
                     up = hash_sum % cores;
                  end
                  h.port = 7'(hpr + up);
               end
            end
         end
         ttfnh_pkg::LINK_TO_CORE: begin
            rack = r.dst / hpr;
            if (rack <= 127) begin
               h.kind = ttfnh_pkg::KIND_PORT;
               h.port = 7'(rack);
            end
         end
         default: begin
            h.kind = ttfnh_pkg::KIND_PORT;
            h.port = 7'(r.dst % hpr);
         end
      endcase
      return h;
   endfunction

   // result check, every strobe against the oldest prediction
   always @(posedge clock) begin
      hop_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_hops.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result kind %0d port %0d host %0d",
                        rsp_next_kind, rsp_next_port, rsp_next_host);
         end else begin
            want = expected_hops.pop_front();
            if (rsp_next_kind !== want.kind || rsp_next_port !== want.port ||
                rsp_next_host !== want.host) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected kind %0d port %0d host %0d, got %0d %0d %0d",
                           want.kind, want.port, want.host,
                           rsp_next_kind, rsp_next_port, rsp_next_host);
            end
         end
      end
   end

   // offer one request, with a random idle gap first; start is left high
   task automatic send_request(input req_type r);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start <= 1'b1;
      req_link_kind <= r.kind;
      req_link_host <= r.lhost;
      req_pkt_src <= r.src;
      req_pkt_dst <= r.dst;
      req_flow_id <= r.flow;
      do @(posedge clock); while (busy !== 1'b0);
      expected_hops.insert(expected_hops.size(), route_packet(r));
   endtask

   // stop sending and wait until every result is in and the block is free
   task automatic wait_idle();
      start <= 1'b0;
      while (expected_hops.size() != 0) @(posedge clock);
      do @(posedge clock); while (busy !== 1'b0);
      repeat (4) @(posedge clock);
   endtask

   // write all three registers back to back, mode word upper bits are ignored
   task automatic write_csrs(input logic [6:0] hpr, input logic [6:0] cores,
                             input logic [6:0] mode_word);
      logic [6:0] word [3];
      logic [1:0] idx [3];
      word = '{hpr, cores, mode_word};
      idx = '{ttfnh_pkg::CSR_HOSTS_PER_RACK, ttfnh_pkg::CSR_CORE_COUNT,
              ttfnh_pkg::CSR_BALANCE_MODE};
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data <= word[i];
         do @(posedge clock); while (csr_ready !== 1'b1);
      end
      csr_valid <= 1'b0;
      cfg_hosts_per_rack = hpr;
      cfg_core_count = cores;
      cfg_balance_mode = mode_word[0];
   endtask

   // host links, arrival and same-rack turnaround under reset values
   task automatic test_host_links();
      wait_idle();
      write_csrs(7'd16, 7'd4, 7'd0);
      send_request('{ttfnh_pkg::LINK_TO_HOST, 10'd0, 10'd0, 10'd0, 32'd0});
      send_request('{ttfnh_pkg::LINK_TO_HOST, 10'd1023, 10'd5, 10'd1023, 32'd0});
      // destination not the host at the link end
      send_request('{ttfnh_pkg::LINK_TO_HOST, 10'd10, 10'd5, 10'd11, 32'd0});
      send_request('{ttfnh_pkg::LINK_FROM_HOST, 10'd7, 10'd3, 10'd7, 32'd0});
      // source not the sending host
      send_request('{ttfnh_pkg::LINK_FROM_HOST, 10'd7, 10'd3, 10'd9, 32'd0});
      send_request('{ttfnh_pkg::LINK_FROM_HOST, 10'd1, 10'd1, 10'd15, 32'd0});
   endtask

   // spraying across uplinks, stale entries after lowering the count, hashing
   task automatic test_uplink_balance();
      wait_idle();
      write_csrs(7'd16, 7'd8, 7'd0);
      repeat (5) send_request('{ttfnh_pkg::LINK_FROM_HOST, 10'd3, 10'd3, 10'd100, $urandom});
      wait_idle();
      // entry now above the new core count
      write_csrs(7'd16, 7'd3, 7'd0);
      repeat (2) send_request('{ttfnh_pkg::LINK_FROM_HOST, 10'd3, 10'd3, 10'd100, $urandom});
      wait_idle();
      write_csrs(7'd16, 7'd4, 7'h7f);
      // id sum wraps past 32 bits
      send_request('{ttfnh_pkg::LINK_FROM_HOST, 10'd1023, 10'd1023, 10'd0, 32'hffff_ffff});
   endtask

   // rack and port selection with counts clamped at both ends
   task automatic test_fabric_links();
      wait_idle();
      write_csrs(7'd0, 7'd127, 7'd1);
      send_request('{ttfnh_pkg::LINK_TO_CORE, 10'd1023, 10'd1023, 10'd127, 32'd0});
      // rack index too wide
      send_request('{ttfnh_pkg::LINK_TO_CORE, 10'd0, 10'd0, 10'd128, 32'd0});
      send_request('{ttfnh_pkg::LINK_FROM_CORE, 10'd0, 10'd0, 10'd1023, 32'hffff_ffff});
      send_request('{ttfnh_pkg::LINK_FROM_HOST, 10'd0, 10'd0, 10'd1, $urandom});
      wait_idle();
      write_csrs(7'd127, 7'd0, 7'h40);
      send_request('{ttfnh_pkg::LINK_TO_CORE, 10'd0, 10'd0, 10'd1023, 32'd0});
      send_request('{ttfnh_pkg::LINK_FROM_CORE, 10'd0, 10'd0, 10'd1023, 32'd0});
      send_request('{ttfnh_pkg::LINK_FROM_HOST, 10'd0, 10'd0, 10'd1023, $urandom});
      send_request('{ttfnh_pkg::LINK_FROM_HOST, 10'd63, 10'd63, 10'd0, $urandom});
   endtask

   // mostly well-formed packets with random content, some pure noise
   function automatic req_type random_request();
      req_type     r;
      int unsigned hpr;
      int unsigned pick;
      int unsigned mate;
      hpr = clamp_count(cfg_hosts_per_rack);
      r.kind = 2'($urandom_range(3));
      r.lhost = 10'($urandom_range(1023));
      r.src = 10'($urandom_range(1023));
      r.dst = 10'($urandom_range(1023));
      r.flow = $urandom;
      // small source pool so spray entries get revisited
      if ($urandom_range(1)) r.src = 10'($urandom_range(15));
      pick = $urandom_range(99);
      if (pick < 10) return r;
      if (pick < 15) begin
         r.kind = ttfnh_pkg::LINK_FROM_HOST;
         if ($urandom_range(1)) r.lhost = r.dst;
      end else if (pick < 55) begin
         r.kind = ttfnh_pkg::LINK_FROM_HOST;
         r.lhost = r.src;
         if ($urandom_range(1)) begin
            mate = (r.src / hpr) * hpr + $urandom_range(hpr - 1);
            if (mate <= 1023) r.dst = 10'(mate);
         end
      end else if (pick < 70) begin
         r.kind = ttfnh_pkg::LINK_TO_HOST;
         if ($urandom_range(7) != 0) r.lhost = r.dst;
      end else if (pick < 85) begin
         r.kind = ttfnh_pkg::LINK_TO_CORE;
      end else begin
         r.kind = ttfnh_pkg::LINK_FROM_CORE;
      end
      return r;
   endfunction

   // random traffic over phases of settings and idle rates
   task automatic test_random_traffic();
      logic [6:0] hpr_pick [5];
      logic [6:0] core_pick [5];
      logic [6:0] hpr;
      logic [6:0] cores;
      hpr_pick = '{7'd0, 7'd127, 7'd1, 7'd64, 7'd65};
      core_pick = '{7'd127, 7'd0, 7'd64, 7'd1, 7'd65};
      for (int phase = 0; phase < 10; phase++) begin
         wait_idle();
         if (phase < 5) begin
            hpr = hpr_pick[phase];
            cores = core_pick[phase];
         end else begin
            hpr = 7'($urandom_range(1, 64));
            cores = 7'($urandom_range(1, 64));
         end
         write_csrs(hpr, cores, {6'($urandom_range(63)), phase[0]});
         case (phase % 3)
            0: idle_pct = 0;
            1: idle_pct = 81;
            default: idle_pct = 19;
         endcase
         for (int n = 0; n < 100; n++) begin
            // sender holds off until every result is back
            if (n == 50) wait_idle();
            send_request(random_request());
         end
      end
   endtask

   initial begin
      foreach (spray_next[i]) spray_next[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // first idle wait covers the spray table clearing pass
      test_host_links();
      test_uplink_balance();
      test_fabric_links();
      test_random_traffic();
      wait_idle();
      repeat (64) @(posedge clock);
      if (mismatches == 0 && expected_hops.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
